FILE: rtl/dps_pkg.sv
package dps_pkg;

  localparam int SP_W    = 7;
  localparam int TICK_W  = 16;
  localparam int SCHED_W = 16;
  localparam int CTIME_W = 32;
  localparam int IDX_W   = 6;
  localparam int NICE_W  = 4;

  // sleep*10 fits in 20 bits, run+sleep shifted by three fits in 20 bits
  localparam int DIV_W   = 20;

  localparam logic [NICE_W-1:0] NICE_IDLE  = 4'd5;
  localparam logic [SP_W+1:0]   PRIO_BIAS  = 9'd5;
  localparam logic [SP_W+1:0]   PRIO_LIMIT = 9'd100;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] chosen_index;
    logic [SP_W-1:0]  chosen_priority;
    logic             overflow;
  } dps_result_t;

endpackage

FILE: rtl/dps_if.sv
interface dps_entry_if;
  logic                         valid;
  logic                         ready;
  logic                         runnable;
  logic [dps_pkg::SP_W-1:0]     static_priority;
  logic [dps_pkg::TICK_W-1:0]   run_ticks;
  logic [dps_pkg::TICK_W-1:0]   sleep_ticks;
  logic [dps_pkg::SCHED_W-1:0]  times_scheduled;
  logic [dps_pkg::CTIME_W-1:0]  creation_time;
  logic                         last;

  modport source (
    output valid, runnable, static_priority, run_ticks, sleep_ticks,
           times_scheduled, creation_time, last,
    input  ready
  );
  modport sink (
    input  valid, runnable, static_priority, run_ticks, sleep_ticks,
           times_scheduled, creation_time, last,
    output ready
  );
endinterface

interface dps_choice_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [dps_pkg::IDX_W-1:0]   chosen_index;
  logic [dps_pkg::SP_W-1:0]    chosen_priority;
  logic                        overflow;

  modport source (
    output valid, found, chosen_index, chosen_priority, overflow,
    input  ready
  );
  modport sink (
    input  valid, found, chosen_index, chosen_priority, overflow,
    output ready
  );
endinterface

FILE: rtl/dps_nice_div.sv
module dps_nice_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dps_pkg::TICK_W-1:0]  run_ticks,
  input  logic [dps_pkg::TICK_W-1:0]  sleep_ticks,
  output logic                        done,
  output logic [dps_pkg::NICE_W-1:0]  nice
);
  import dps_pkg::*;

  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  den;
  logic [NICE_W-1:0] quo;
  logic [1:0]        step;
  logic              active;
  logic              zero_total;
  logic [TICK_W:0]   total;
  logic              ge;

  assign total = {1'b0, run_ticks} + {1'b0, sleep_ticks};
  assign ge    = (rem >= den);
  assign nice  = zero_total ? NICE_IDLE : quo;

  // Control; hold done until the next start
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= '0;
      done   <= 1'b0;
    end else begin
      if (start) begin
        active <= 1'b1;
        step   <= '0;
        done   <= 1'b0;
      end else if (active) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Restoring divide, one quotient bit per cycle, divisor walks right
  always_ff @(posedge clk) begin
    if (start) begin
      rem        <= {1'b0, sleep_ticks, 3'b000} + {3'b000, sleep_ticks, 1'b0};
      den        <= {total, 3'b000};
      quo        <= '0;
      zero_total <= (total == '0);
    end else if (active) begin
      if (ge) begin
        rem <= rem - den;
      end
      den <= {1'b0, den[DIV_W-1:1]};
      quo <= {quo[NICE_W-2:0], ge};
    end
  end

endmodule

FILE: rtl/dps_select.sv
module dps_select #(
  parameter int MAX_PROCS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         upd,
  input  logic                         runnable,
  input  logic [dps_pkg::SP_W-1:0]     static_priority,
  input  logic [dps_pkg::NICE_W-1:0]   nice,
  input  logic [dps_pkg::SCHED_W-1:0]  times_scheduled,
  input  logic [dps_pkg::CTIME_W-1:0]  creation_time,
  input  logic                         last,
  output dps_pkg::dps_result_t         res
);
  import dps_pkg::*;

  localparam int CW = $clog2(MAX_PROCS + 2);
  localparam logic [CW-1:0] TABLE_SIZE = CW'(MAX_PROCS);

  logic [CW-1:0]      entry_counter;
  logic [CW-1:0]      entry_counter_next;
  logic               best_valid;
  logic               best_valid_next;
  logic [IDX_W-1:0]   best_index;
  logic [IDX_W-1:0]   best_index_next;
  logic [SP_W-1:0]    best_priority;
  logic [SP_W-1:0]    best_priority_next;
  logic [SCHED_W-1:0] best_sched_count;
  logic [SCHED_W-1:0] best_sched_count_next;
  logic [CTIME_W-1:0] best_creation;
  logic [CTIME_W-1:0] best_creation_next;

  logic [SP_W+1:0]    biased;
  logic [SP_W-1:0]    dp;
  logic [CW+IDX_W-1:0] pos_ext;
  logic               take;

  // static + 5 - niceness, clamped to 0..100
  assign biased = {2'b00, static_priority} + PRIO_BIAS;
  always_comb begin
    if (biased < {5'd0, nice}) begin
      dp = '0;
    end else if ((biased - {5'd0, nice}) > PRIO_LIMIT) begin
      dp = PRIO_LIMIT[SP_W-1:0];
    end else begin
      dp = SP_W'(biased - {5'd0, nice});
    end
  end

  assign pos_ext = {{IDX_W{1'b0}}, entry_counter};

  always_comb begin
    if (!best_valid) begin
      take = 1'b1;
    end else if (dp != best_priority) begin
      take = dp < best_priority;
    end else if (times_scheduled != best_sched_count) begin
      take = times_scheduled < best_sched_count;
    end else begin
      take = creation_time > best_creation;
    end
  end

  always_comb begin
    best_valid_next       = best_valid;
    best_index_next       = best_index;
    best_priority_next    = best_priority;
    best_sched_count_next = best_sched_count;
    best_creation_next    = best_creation;
    if (runnable && take && (entry_counter < TABLE_SIZE)) begin
      best_valid_next       = 1'b1;
      best_index_next       = pos_ext[IDX_W-1:0];
      best_priority_next    = dp;
      best_sched_count_next = times_scheduled;
      best_creation_next    = creation_time;
    end
    entry_counter_next = entry_counter;
    if (entry_counter <= TABLE_SIZE) begin
      entry_counter_next = entry_counter + CW'(1);
    end
  end

  always_comb begin
    res.found           = best_valid_next;
    res.chosen_index    = best_valid_next ? best_index_next : '0;
    res.chosen_priority = best_valid_next ? best_priority_next : '0;
    res.overflow        = entry_counter_next > TABLE_SIZE;
  end

  always_ff @(posedge clk) begin
    if (rst || (upd && last)) begin
      entry_counter    <= '0;
      best_valid       <= 1'b0;
      best_index       <= '0;
      best_priority    <= '0;
      best_sched_count <= '0;
      best_creation    <= '0;
    end else if (upd) begin
      entry_counter    <= entry_counter_next;
      best_valid       <= best_valid_next;
      best_index       <= best_index_next;
      best_priority    <= best_priority_next;
      best_sched_count <= best_sched_count_next;
      best_creation    <= best_creation_next;
    end
  end

endmodule

FILE: rtl/dynamic_priority_process_select.sv
// Dynamic-priority process selector.
// entry (sink): one process-table entry per item, in scan order, with a
//   last flag on the final entry of the scan.
// choice (source): one item per scan, issued for the entry flagged last:
//   found, chosen index, its dynamic priority and a table overflow flag.
// Each entry passes through an accept cycle, a divide in which a
//   restoring divider forms the niceness quotient one bit at a time, and a
//   selection cycle in which the next entry can already be accepted.
// The result sits in an output register; the next scan proceeds while it
//   waits. Only when another last entry finishes while that register is
//   still full does the block hold the entry and stall entry.ready.
// Entries past the first MAX_PROCS of a scan are ignored apart from
//   setting overflow.
// Reset (rst, synchronous) drops any entry in flight and any pending
//   result and starts a fresh scan.
module dynamic_priority_process_select #(
  parameter int MAX_PROCS = 64
) (
  input  logic         clk,
  input  logic         rst,
  dps_entry_if.sink    entry,
  dps_choice_if.source choice
);
  import dps_pkg::*;

  typedef enum logic {
    IDLE,
    DIV
  } state_t;

  state_t             state;
  logic               runnable;
  logic [SP_W-1:0]    static_priority;
  logic [SCHED_W-1:0] times_scheduled;
  logic [CTIME_W-1:0] creation_time;
  logic               last;

  logic               div_done;
  logic [NICE_W-1:0]  nice;
  logic               can_finish;
  logic               upd;
  logic               accept;
  dps_result_t        res;

  assign can_finish  = !last || !choice.valid || choice.ready;
  assign upd         = (state == DIV) && div_done && can_finish;
  assign entry.ready = (state == IDLE) || upd;
  assign accept      = entry.valid && entry.ready;

  dps_nice_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (accept),
    .run_ticks   (entry.run_ticks),
    .sleep_ticks (entry.sleep_ticks),
    .done        (div_done),
    .nice        (nice)
  );

  dps_select #(
    .MAX_PROCS (MAX_PROCS)
  ) u_sel (
    .clk             (clk),
    .rst             (rst),
    .upd             (upd),
    .runnable        (runnable),
    .static_priority (static_priority),
    .nice            (nice),
    .times_scheduled (times_scheduled),
    .creation_time   (creation_time),
    .last            (last),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      choice.valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (accept) begin
            state <= DIV;
          end
        end
        DIV: begin
          if (upd && !accept) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      if (upd && last) begin
        choice.valid <= 1'b1;
      end else if (choice.ready) begin
        choice.valid <= 1'b0;
      end
    end
  end

  // Hold the entry fields for the whole divide
  always_ff @(posedge clk) begin
    if (accept) begin
      runnable        <= entry.runnable;
      static_priority <= entry.static_priority;
      times_scheduled <= entry.times_scheduled;
      creation_time   <= entry.creation_time;
      last            <= entry.last;
    end
  end

  always_ff @(posedge clk) begin
    if (upd && last) begin
      choice.found           <= res.found;
      choice.chosen_index    <= res.chosen_index;
      choice.chosen_priority <= res.chosen_priority;
      choice.overflow        <= res.overflow;
    end
  end

  a_div_restarts: assert property (@(posedge clk) disable iff (rst)
    accept |=> !div_done)
    else $error("divider did not restart on a new entry");

  a_one_entry_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !entry.ready)
    else $error("entry accepted while previous one still dividing");

  a_no_choice_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (choice.valid && !choice.found) |->
      (choice.chosen_index == '0 && choice.chosen_priority == '0))
    else $error("empty scan reported nonzero index or priority");

  a_priority_range: assert property (@(posedge clk) disable iff (rst)
    choice.valid |-> (choice.chosen_priority <= PRIO_LIMIT[SP_W-1:0]))
    else $error("dynamic priority above limit");

  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    (choice.valid && !choice.ready) |=> choice.valid)
    else $error("pending result dropped");

endmodule

FILE: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dps_pkg::*;

  localparam int MAX_PROCS   = 64;
  localparam int N_DIRECTED  = 17;
  localparam int HOLD_CYCLES = 400;

  typedef enum {PH_FREE, PH_TX_GAP, PH_RX_STALL, PH_BOTH, PH_PRESSURE} phase_t;

  typedef struct packed {
    logic               runnable;
    logic [SP_W-1:0]    static_priority;
    logic [TICK_W-1:0]  run_ticks;
    logic [TICK_W-1:0]  sleep_ticks;
    logic [SCHED_W-1:0] times_scheduled;
    logic [CTIME_W-1:0] creation_time;
    logic               last;
  } entry_t;

  typedef struct packed {
    entry_t      e;
    logic        typed;
    dps_result_t res;
  } row_t;

  // entry fields, then whether the scan result is written out here
  localparam row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // not runnable, every other field at its top
    '{'{1'b0, 7'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 1'b1},
      1'b1, '{1'b0, 6'd0, 7'd0, 1'b0}},
    // no ticks at all: niceness 5
    '{'{1'b1, 7'd0, 16'h0000, 16'h0000, 16'h0000, 32'h00000000, 1'b1},
      1'b1, '{1'b1, 6'd0, 7'd0, 1'b0}},
    '{'{1'b1, 7'd127, 16'h0000, 16'h0000, 16'h0000, 32'h00000000, 1'b1},
      1'b1, '{1'b1, 6'd0, 7'd100, 1'b0}},
    // all sleep: clamp at zero
    '{'{1'b1, 7'd0, 16'h0000, 16'hFFFF, 16'h0000, 32'h00000000, 1'b1},
      1'b1, '{1'b1, 6'd0, 7'd0, 1'b0}},
    // all run: clamp at the top
    '{'{1'b1, 7'd100, 16'hFFFF, 16'h0000, 16'hFFFF, 32'hFFFFFFFF, 1'b1},
      1'b1, '{1'b1, 6'd0, 7'd100, 1'b0}},
    '{'{1'b1, 7'd50, 16'hFFFF, 16'hFFFF, 16'h1234, 32'h89ABCDEF, 1'b1},
      1'b1, '{1'b1, 6'd0, 7'd50, 1'b0}},
    // equal priority: fewer schedules wins, then later creation, equal keeps
    '{'{1'b1, 7'd50, 16'h0001, 16'h0001, 16'h0003, 32'h0000000A, 1'b0},
      1'b0, '{1'b0, 6'd0, 7'd0, 1'b0}},
    '{'{1'b1, 7'd50, 16'h0000, 16'h0000, 16'h0002, 32'h00000005, 1'b0},
      1'b0, '{1'b0, 6'd0, 7'd0, 1'b0}},
    '{'{1'b1, 7'd50, 16'h0002, 16'h0002, 16'h0002, 32'h00000006, 1'b0},
      1'b0, '{1'b0, 6'd0, 7'd0, 1'b0}},
    '{'{1'b1, 7'd50, 16'h0009, 16'h0009, 16'h0002, 32'h00000006, 1'b0},
      1'b0, '{1'b0, 6'd0, 7'd0, 1'b0}},
    '{'{1'b0, 7'd0, 16'h0000, 16'h0000, 16'h0000, 32'h00000000, 1'b1},
      1'b1, '{1'b1, 6'd2, 7'd50, 1'b0}},
    // priority beats schedule count and creation time
    '{'{1'b1, 7'd60, 16'h0000, 16'h0000, 16'h0000, 32'hFFFFFFFF, 1'b0},
      1'b0, '{1'b0, 6'd0, 7'd0, 1'b0}},
    '{'{1'b1, 7'd40, 16'h0003, 16'h0007, 16'hFFFF, 32'h00000000, 1'b0},
      1'b0, '{1'b0, 6'd0, 7'd0, 1'b0}},
    '{'{1'b1, 7'd39, 16'h0000, 16'h0000, 16'h0000, 32'h00000000, 1'b1},
      1'b1, '{1'b1, 6'd1, 7'd38, 1'b0}},
    '{'{1'b1, 7'd7, 16'd123, 16'd4567, 16'd9, 32'h12345678, 1'b0},
      1'b0, '{1'b0, 6'd0, 7'd0, 1'b0}},
    '{'{1'b1, 7'd101, 16'd999, 16'd1, 16'd9, 32'h00000001, 1'b0},
      1'b0, '{1'b0, 6'd0, 7'd0, 1'b0}},
    '{'{1'b1, 7'd20, 16'hFFFF, 16'd1, 16'd0, 32'h80000000, 1'b1},
      1'b0, '{1'b0, 6'd0, 7'd0, 1'b0}}
  };

  logic clk;
  logic rst;

  dps_entry_if  entry_bus ();
  dps_choice_if choice_bus ();

  dynamic_priority_process_select #(
    .MAX_PROCS (MAX_PROCS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .entry  (entry_bus),
    .choice (choice_bus)
  );

  phase_t phase = PH_FREE;

  // scan state mirrored from the block
  logic [6:0]         scan_count;
  logic               best_ok;
  logic [IDX_W-1:0]   best_idx;
  logic [SP_W-1:0]    best_prio;
  logic [SCHED_W-1:0] best_sched;
  logic [CTIME_W-1:0] best_ctime;

  dps_result_t pending_choices [$];
  int          bad_choices = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [SP_W-1:0] dyn_priority(logic [SP_W-1:0] sp,
                                                   logic [TICK_W-1:0] run,
                                                   logic [TICK_W-1:0] slp);
    int unsigned total;
    int unsigned nice;
    int          d;
    total = int'(run) + int'(slp);
    nice  = 5;
    if (total != 0) nice = (int'(slp) * 10) / total;
    d = int'(sp) - int'(nice) + 5;
    if (d < 0) d = 0;
    if (d > 100) d = 100;
    return 7'(d);
  endfunction

  task automatic clear_scan();
    scan_count = '0;
    best_ok    = 1'b0;
    best_idx   = '0;
    best_prio  = '0;
    best_sched = '0;
    best_ctime = '0;
  endtask

  task automatic predict_selection(entry_t e);
    logic [SP_W-1:0] dp;
    logic            take;
    dps_result_t     r;
    if (scan_count < MAX_PROCS) begin
      dp = dyn_priority(e.static_priority, e.run_ticks, e.sleep_ticks);
      if (e.runnable) begin
        if (!best_ok) take = 1'b1;
        else if (dp != best_prio) take = dp < best_prio;
        else if (e.times_scheduled != best_sched) take = e.times_scheduled < best_sched;
        else take = e.creation_time > best_ctime;
        if (take) begin
          best_ok    = 1'b1;
          best_idx   = scan_count[IDX_W-1:0];
          best_prio  = dp;
          best_sched = e.times_scheduled;
          best_ctime = e.creation_time;
        end
      end
    end
    if (scan_count <= MAX_PROCS) scan_count++;
    if (e.last) begin
      r.found           = best_ok;
      r.chosen_index    = best_ok ? best_idx : '0;
      r.chosen_priority = best_ok ? best_prio : '0;
      r.overflow        = scan_count > MAX_PROCS;
      pending_choices.push_back(r);
      clear_scan();
    end
  endtask

  function automatic int tx_gap_pct(phase_t p);
    case (p)
      PH_TX_GAP: return 62;
      PH_BOTH:   return 26;
      default:   return 0;
    endcase
  endfunction

  task automatic offer_entry(entry_t e);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_gap_pct(phase)) begin
      entry_bus.valid <= 1'b0;
      @(negedge clk);
    end
    entry_bus.valid           <= 1'b1;
    entry_bus.runnable        <= e.runnable;
    entry_bus.static_priority <= e.static_priority;
    entry_bus.run_ticks       <= e.run_ticks;
    entry_bus.sleep_ticks     <= e.sleep_ticks;
    entry_bus.times_scheduled <= e.times_scheduled;
    entry_bus.creation_time   <= e.creation_time;
    entry_bus.last            <= e.last;
    @(posedge clk);
    while (!entry_bus.ready) @(posedge clk);
    predict_selection(e);
  endtask

  function automatic entry_t rand_entry(int run_pct, logic last);
    entry_t e;
    e.runnable = $urandom_range(0, 99) < run_pct;
    case ($urandom_range(0, 9))
      0:       e.static_priority = 7'd0;
      1:       e.static_priority = 7'd100;
      2:       e.static_priority = 7'($urandom_range(101, 127));
      3, 4:    e.static_priority = 7'($urandom_range(48, 52));
      default: e.static_priority = 7'($urandom_range(0, 100));
    endcase
    case ($urandom_range(0, 7))
      0: begin
        e.run_ticks   = '0;
        e.sleep_ticks = '0;
      end
      1: begin
        e.run_ticks   = '0;
        e.sleep_ticks = 16'($urandom);
      end
      2: begin
        e.run_ticks   = 16'($urandom);
        e.sleep_ticks = '0;
      end
      3: begin
        e.run_ticks   = 16'hFFFF;
        e.sleep_ticks = 16'($urandom);
      end
      4, 5: begin
        e.run_ticks   = 16'($urandom_range(0, 15));
        e.sleep_ticks = 16'($urandom_range(0, 15));
      end
      default: begin
        e.run_ticks   = 16'($urandom);
        e.sleep_ticks = 16'($urandom);
      end
    endcase
    // small pools make ties on schedule count and creation time common
    case ($urandom_range(0, 3))
      0, 1:    e.times_scheduled = 16'($urandom_range(0, 3));
      2:       e.times_scheduled = 16'hFFFF;
      default: e.times_scheduled = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0, 1:    e.creation_time = 32'($urandom_range(0, 3));
      2:       e.creation_time = 32'hFFFFFFFF;
      default: e.creation_time = $urandom;
    endcase
    e.last = last;
    return e;
  endfunction

  function automatic int rand_run_pct();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 30;
      2, 3:    return 80;
      default: return 100;
    endcase
  endfunction

  task automatic run_scans(int budget, int short_max, bit allow_long);
    int sent;
    int len;
    int run_pct;
    sent = 0;
    while (sent < budget) begin
      if (allow_long && $urandom_range(0, 9) == 0) len = $urandom_range(9, 40);
      else len = $urandom_range(1, short_max);
      run_pct = rand_run_pct();
      for (int i = 0; i < len; i++) offer_entry(rand_entry(run_pct, i == len - 1));
      sent += len;
    end
  endtask

  task automatic run_table_scan(int len);
    int run_pct;
    run_pct = rand_run_pct();
    for (int i = 0; i < len; i++) offer_entry(rand_entry(run_pct, i == len - 1));
  endtask

  // receiver: random stalls per phase, one long hold-off when pressure starts
  initial begin
    int hold_left;
    bit hold_done;
    int stall_pct;
    hold_left = 0;
    hold_done = 0;
    choice_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase == PH_PRESSURE && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      case (phase)
        PH_RX_STALL: stall_pct = 62;
        PH_BOTH:     stall_pct = 26;
        default:     stall_pct = 0;
      endcase
      if (hold_left > 0) begin
        choice_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        choice_bus.ready <= $urandom_range(0, 99) >= stall_pct;
      end
    end
  end

  always @(posedge clk) begin : check_choice
    dps_result_t want;
    if (!rst && choice_bus.valid && choice_bus.ready) begin
      if (pending_choices.size() == 0) begin
        bad_choices++;
        if (bad_choices <= 10)
          $display("unexpected choice: found=%0d index=%0d prio=%0d overflow=%0d",
                   choice_bus.found, choice_bus.chosen_index,
                   choice_bus.chosen_priority, choice_bus.overflow);
      end else begin
        want = pending_choices.pop_front();
        if (choice_bus.found !== want.found ||
            choice_bus.chosen_index !== want.chosen_index ||
            choice_bus.chosen_priority !== want.chosen_priority ||
            choice_bus.overflow !== want.overflow) begin
          bad_choices++;
          if (bad_choices <= 10)
            $display({"choice mismatch: exp found=%0d index=%0d prio=%0d overflow=%0d,",
                      " got found=%0d index=%0d prio=%0d overflow=%0d"},
                     want.found, want.chosen_index, want.chosen_priority, want.overflow,
                     choice_bus.found, choice_bus.chosen_index,
                     choice_bus.chosen_priority, choice_bus.overflow);
        end
      end
    end
  end

  initial begin
    dps_result_t typed_res;
    entry_bus.valid           = 1'b0;
    entry_bus.runnable        = 1'b0;
    entry_bus.static_priority = '0;
    entry_bus.run_ticks       = '0;
    entry_bus.sleep_ticks     = '0;
    entry_bus.times_scheduled = '0;
    entry_bus.creation_time   = '0;
    entry_bus.last            = 1'b0;
    rst = 1'b1;
    clear_scan();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_entry(DIRECTED_ROWS[i].e);
      // replace the prediction with the result written in the table
      if (DIRECTED_ROWS[i].typed) begin
        typed_res = DIRECTED_ROWS[i].res;
        pending_choices[pending_choices.size() - 1] = typed_res;
      end
    end

    run_scans(130, 8, 1);
    phase = PH_TX_GAP;
    run_scans(130, 8, 1);
    phase = PH_RX_STALL;
    run_scans(130, 8, 1);
    phase = PH_BOTH;
    run_scans(130, 8, 1);
    // short scans back to back while the receiver holds off
    phase = PH_PRESSURE;
    run_scans(60, 2, 0);
    phase = PH_FREE;
    run_table_scan(MAX_PROCS);
    run_table_scan(MAX_PROCS + 1);
    run_table_scan(MAX_PROCS + 2);

    @(negedge clk);
    entry_bus.valid <= 1'b0;
    while (pending_choices.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (bad_choices == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
